>>> sv/dhlc_pkg.sv
// Shared types and constants of the detector hit clustering block.
package dhlc_pkg;

   // Field widths of one buffered entry.
   localparam int VolW  = 16;
   localparam int EnW   = 24;
   localparam int PosW  = 24;
   localparam int TimeW = 48;
   localparam int KindW = 2;
   localparam int CsrW  = 24;
   localparam int CsrAW = 3;
   localparam int NumDistRegs = 4;

   // Squared distance: three 48-bit squares summed.
   localparam int DistW = 50;
   // Rounded dividend magnitude and divisor of the centroid division.
   localparam int NumW = 50;
   localparam int DenW = 25;

   localparam logic [EnW-1:0] EnMax = '1;

   // Configuration register indexes.
   localparam logic [CsrAW-1:0] CSR_KIND0_DIST = 3'd0;
   localparam logic [CsrAW-1:0] CSR_KIND1_DIST = 3'd1;
   localparam logic [CsrAW-1:0] CSR_KIND2_DIST = 3'd2;
   localparam logic [CsrAW-1:0] CSR_KIND3_DIST = 3'd3;
   localparam logic [CsrAW-1:0] CSR_CLUSTER_MASK = 3'd4;
   localparam logic [CsrAW-1:0] CSR_REJECT_MASK = 3'd5;

   // One buffered entry: a cluster or a plain hit.
   typedef struct packed {
      logic [TimeW-1:0]     time_ps;
      logic [2:0][PosW-1:0] pos;
      logic [EnW-1:0]       energy;
      logic                 clus;
      logic [KindW-1:0]     kind;
      logic [VolW-1:0]      volume;
   } entry_type;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic            start;
      logic [NumW-1:0] dividend;
      logic [DenW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [NumW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_X,
      ST_SCAN_Y,
      ST_SCAN_Z,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_MRG_RD,
      ST_MRG_MC,
      ST_MRG_MH,
      ST_MRG_SUM,
      ST_MRG_DIV,
      ST_MRG_WR,
      ST_ADD,
      ST_FIN,
      ST_REJ_RDI,
      ST_REJ_CHKI,
      ST_REJ_RDJ,
      ST_REJ_CHKJ,
      ST_ONE,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_WAIT
   } state_type;

endpackage

>>> sv/dhlc_entry_mem.sv
// Entry buffer: one write port and one read port with registered read data.
module dhlc_entry_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  dhlc_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output dhlc_pkg::entry_type rd_data
);

   dhlc_pkg::entry_type mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/dhlc_div.sv
// Restoring divider for the centroid, one quotient bit per cycle.
module dhlc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dhlc_pkg::div_req_type req,
   output dhlc_pkg::div_rsp_type rsp
);

   localparam int NW = dhlc_pkg::NumW;
   localparam int DW = dhlc_pkg::DenW;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;

   // On start, load the operands; while busy, shift in the next dividend bit and try to subtract.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff[DW-1:0], quo_ff[NW-1]};
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> sv/detector_hit_local_clustering.sv
// Top level of the detector hit clustering block: sequencer, entry buffer and divider.
//
// Hits of one event are taken one at a time and gathered in an entry buffer of
// MAX_ENTRIES entries held in a single-port-read memory. A clustered hit scans
// every buffered entry: each is read, and a cluster of the same volume then has
// its three squares formed through one shared multiplier and is compared. A
// merge adds three centroid divisions, none when both energies are zero, in an
// iterative divider of one bit per cycle. A plain hit is appended with no scan.
// At the last hit, the rejection check walks entry pairs, and the results then
// leave one item at a time, each held until rsp_tready. The next hit is taken
// once the current one and its results are done. No clearing pass is needed
// after reset.
module detector_hit_local_clustering #(
   parameter int MAX_ENTRIES = 64,
   parameter int NUM_KINDS   = 4
) (
   input  logic         clock,
   input  logic         reset,
   // Hit channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: volume_id, hit_energy, pos_x, pos_y, pos_z, hit_time
   input  logic [159:0] req_tdata,
   // tuser: volume_kind
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_volume_id, out_energy, out_x, out_y, out_z, out_time
   output logic [159:0] rsp_tdata,
   // tuser: event_rejected, buffer_overflow
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   // Configuration writes.
   input  logic                         csr_we,
   input  logic [dhlc_pkg::CsrAW-1:0]   csr_addr,
   input  logic [dhlc_pkg::CsrW-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = dhlc_pkg::PosW;
   localparam int EW = dhlc_pkg::EnW;

   dhlc_pkg::state_type state_ff, state_in;
   dhlc_pkg::entry_type hit_ff, hit_in;
   dhlc_pkg::entry_type rd_data, wr_data;
   dhlc_pkg::div_req_type div_req;
   dhlc_pkg::div_rsp_type div_rsp;

   logic                       last_ff, last_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       ovf_ff, ovf_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              jdx_ff, jdx_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [dhlc_pkg::DistW-1:0] acc_ff, acc_in;
   logic [dhlc_pkg::DistW-1:0] best_d_ff, best_d_in;
   logic [AW-1:0]              best_ff, best_in;
   logic                       found_ff, found_in;
   logic [1:0]                 axis_ff, axis_in;
   logic signed [48:0]         pc_ff, pc_in;
   logic signed [48:0]         ph_ff, ph_in;
   logic                       neg_ff, neg_in;
   logic [2:0][PW-1:0]         newpos_ff, newpos_in;
   logic [dhlc_pkg::VolW-1:0]  voli_ff, voli_in;
   logic                       rej_ff, rej_in;
   logic                       single_ff, single_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [159:0]               rsp_data_ff, rsp_data_in;
   logic [1:0]                 rsp_user_ff, rsp_user_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [3:0][EW-1:0]         dist_ff;
   logic [3:0]                 cmask_ff, rmask_ff;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [1:0]                 sq_axis;
   logic signed [PW:0]         sq_diff;
   logic [PW:0]                sq_mag;
   logic [dhlc_pkg::DistW-1:0] sq_val;
   logic [PW-1:0]              c_sel, h_sel;
   logic signed [49:0]         num;
   logic [49:0]                num_mag;
   logic [dhlc_pkg::DenW-1:0]  den;
   logic [PW-1:0]              q_pos;
   logic [EW:0]                en_sum;
   logic                       hit_clus;
   logic                       rd_rej;
   logic [CW-1:0]              idx_nx, jdx_nx;

   dhlc_entry_mem #(
      .DEPTH(MAX_ENTRIES),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   dhlc_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   // Shared squaring unit for the distance scan.
   always_comb begin
      sq_diff = $signed({hit_ff.pos[sq_axis][PW-1], hit_ff.pos[sq_axis]})
              - $signed({rd_data.pos[sq_axis][PW-1], rd_data.pos[sq_axis]});
      sq_mag  = sq_diff[PW] ? (PW+1)'(-sq_diff) : sq_diff;
      sq_val  = sq_mag * sq_mag;
   end

   // Centroid operands for the coordinate being merged.
   always_comb begin
      c_sel   = rd_data.pos[axis_ff];
      h_sel   = hit_ff.pos[axis_ff];
      num     = 50'(pc_ff) + 50'(ph_ff);
      num_mag = num[49] ? 50'(-num) : num;
      den     = {1'b0, rd_data.energy} + {1'b0, hit_ff.energy};
      q_pos   = div_rsp.quotient[PW-1:0];
      en_sum  = {1'b0, rd_data.energy} + {1'b0, hit_ff.energy};
   end

   // An entry that counts for rejection: a cluster of a reject-enabled kind.
   assign rd_rej   = rd_data.clus && (32'(rd_data.kind) < NUM_KINDS) && rmask_ff[rd_data.kind];
   assign hit_clus = (32'(req_tuser) < NUM_KINDS) && cmask_ff[req_tuser];
   assign idx_nx   = idx_ff + 1'b1;
   assign jdx_nx   = jdx_ff + 1'b1;

   // Sequencer: next state, datapath updates and memory accesses.
   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      addr_in      = addr_ff;
      acc_in       = acc_ff;
      best_d_in    = best_d_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      axis_in      = axis_ff;
      pc_in        = pc_ff;
      ph_in        = ph_ff;
      neg_in       = neg_ff;
      newpos_in    = newpos_ff;
      voli_in      = voli_ff;
      rej_in       = rej_ff;
      single_in    = single_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[AW-1:0];
      wr_data      = hit_ff;
      sq_axis      = 2'd0;
      div_req      = '{start: 1'b0, dividend: num_mag + 50'(den >> 1), divisor: den};

      unique case (state_ff)
         dhlc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               hit_in.volume  = req_tdata[15:0];
               hit_in.energy  = req_tdata[39:16];
               hit_in.pos[0]  = req_tdata[63:40];
               hit_in.pos[1]  = req_tdata[87:64];
               hit_in.pos[2]  = req_tdata[111:88];
               hit_in.time_ps = req_tdata[159:112];
               hit_in.kind    = req_tuser;
               hit_in.clus    = hit_clus;
               last_in  = req_tlast;
               idx_in   = '0;
               addr_in  = '0;
               found_in = 1'b0;
               if (!hit_clus) begin
                  state_in = dhlc_pkg::ST_ADD;
               end else if (cnt_ff == '0) begin
                  state_in = dhlc_pkg::ST_DECIDE;
               end else begin
                  state_in = dhlc_pkg::ST_SCAN_RD;
               end
            end
         end
         dhlc_pkg::ST_SCAN_RD: begin
            state_in = dhlc_pkg::ST_SCAN_X;
         end
         dhlc_pkg::ST_SCAN_X: begin
            sq_axis = 2'd0;
            acc_in  = sq_val;
            if (!rd_data.clus || rd_data.volume != hit_ff.volume) begin
               idx_in  = idx_nx;
               addr_in = idx_nx[AW-1:0];
               state_in = (idx_nx == cnt_ff) ? dhlc_pkg::ST_DECIDE : dhlc_pkg::ST_SCAN_RD;
            end else begin
               state_in = dhlc_pkg::ST_SCAN_Y;
            end
         end
         dhlc_pkg::ST_SCAN_Y: begin
            sq_axis  = 2'd1;
            acc_in   = acc_ff + sq_val;
            state_in = dhlc_pkg::ST_SCAN_Z;
         end
         dhlc_pkg::ST_SCAN_Z: begin
            sq_axis  = 2'd2;
            acc_in   = acc_ff + sq_val;
            state_in = dhlc_pkg::ST_SCAN_CMP;
         end
         dhlc_pkg::ST_SCAN_CMP: begin
            // Strict compare keeps the earliest of equally near clusters.
            if (!found_ff || acc_ff < best_d_ff) begin
               found_in  = 1'b1;
               best_in   = idx_ff[AW-1:0];
               best_d_in = acc_ff;
            end
            idx_in  = idx_nx;
            addr_in = idx_nx[AW-1:0];
            state_in = (idx_nx == cnt_ff) ? dhlc_pkg::ST_DECIDE : dhlc_pkg::ST_SCAN_RD;
         end
         dhlc_pkg::ST_DECIDE: begin
            if (found_ff && best_d_ff < dhlc_pkg::DistW'(dist_ff[hit_ff.kind])) begin
               addr_in  = best_ff;
               axis_in  = 2'd0;
               state_in = dhlc_pkg::ST_MRG_RD;
            end else begin
               state_in = dhlc_pkg::ST_ADD;
            end
         end
         dhlc_pkg::ST_MRG_RD: begin
            state_in = dhlc_pkg::ST_MRG_MC;
         end
         dhlc_pkg::ST_MRG_MC: begin
            pc_in    = $signed(c_sel) * $signed({1'b0, rd_data.energy});
            state_in = dhlc_pkg::ST_MRG_MH;
         end
         dhlc_pkg::ST_MRG_MH: begin
            ph_in    = $signed(h_sel) * $signed({1'b0, hit_ff.energy});
            state_in = dhlc_pkg::ST_MRG_SUM;
         end
         dhlc_pkg::ST_MRG_SUM: begin
            neg_in = num[49];
            if (den == '0) begin
               // Both energies zero: the cluster keeps its position.
               newpos_in[axis_ff] = c_sel;
               axis_in  = axis_ff + 1'b1;
               state_in = (axis_ff == 2'd2) ? dhlc_pkg::ST_MRG_WR : dhlc_pkg::ST_MRG_MC;
            end else begin
               div_req.start = 1'b1;
               state_in = dhlc_pkg::ST_MRG_DIV;
            end
         end
         dhlc_pkg::ST_MRG_DIV: begin
            if (div_rsp.done) begin
               newpos_in[axis_ff] = neg_ff ? PW'(-q_pos) : q_pos;
               axis_in  = axis_ff + 1'b1;
               state_in = (axis_ff == 2'd2) ? dhlc_pkg::ST_MRG_WR : dhlc_pkg::ST_MRG_MC;
            end
         end
         dhlc_pkg::ST_MRG_WR: begin
            wr_en   = 1'b1;
            wr_addr = best_ff;
            wr_data = rd_data;
            wr_data.pos = newpos_ff;
            wr_data.energy = en_sum[EW] ? dhlc_pkg::EnMax : en_sum[EW-1:0];
            if (hit_ff.time_ps < rd_data.time_ps) begin
               wr_data.time_ps = hit_ff.time_ps;
            end
            state_in = dhlc_pkg::ST_FIN;
         end
         dhlc_pkg::ST_ADD: begin
            if (cnt_ff < CW'(MAX_ENTRIES)) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = dhlc_pkg::ST_FIN;
         end
         dhlc_pkg::ST_FIN: begin
            idx_in  = '0;
            addr_in = '0;
            rej_in  = 1'b0;
            if (!last_ff) begin
               state_in = dhlc_pkg::ST_IDLE;
            end else if (cnt_ff == '0) begin
               state_in = dhlc_pkg::ST_ONE;
            end else begin
               state_in = dhlc_pkg::ST_REJ_RDI;
            end
         end
         dhlc_pkg::ST_REJ_RDI: begin
            state_in = dhlc_pkg::ST_REJ_CHKI;
         end
         dhlc_pkg::ST_REJ_CHKI: begin
            if (rd_rej && idx_nx < cnt_ff) begin
               voli_in  = rd_data.volume;
               jdx_in   = idx_nx;
               addr_in  = idx_nx[AW-1:0];
               state_in = dhlc_pkg::ST_REJ_RDJ;
            end else if (idx_nx == cnt_ff) begin
               idx_in   = '0;
               addr_in  = '0;
               state_in = dhlc_pkg::ST_OUT_RD;
            end else begin
               idx_in   = idx_nx;
               addr_in  = idx_nx[AW-1:0];
               state_in = dhlc_pkg::ST_REJ_RDI;
            end
         end
         dhlc_pkg::ST_REJ_RDJ: begin
            state_in = dhlc_pkg::ST_REJ_CHKJ;
         end
         dhlc_pkg::ST_REJ_CHKJ: begin
            if (rd_rej && rd_data.volume == voli_ff) begin
               rej_in   = 1'b1;
               state_in = dhlc_pkg::ST_ONE;
            end else if (jdx_nx < cnt_ff) begin
               jdx_in   = jdx_nx;
               addr_in  = jdx_nx[AW-1:0];
               state_in = dhlc_pkg::ST_REJ_RDJ;
            end else begin
               // Pair walk for this entry done; move on to the next one.
               idx_in   = idx_nx;
               addr_in  = idx_nx[AW-1:0];
               state_in = dhlc_pkg::ST_REJ_RDI;
            end
         end
         dhlc_pkg::ST_ONE: begin
            // Rejected or empty event: one item with no entry.
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_user_in  = {ovf_ff, rej_ff};
            rsp_last_in  = 1'b1;
            single_in    = 1'b1;
            state_in     = dhlc_pkg::ST_OUT_WAIT;
         end
         dhlc_pkg::ST_OUT_RD: begin
            state_in = dhlc_pkg::ST_OUT_LOAD;
         end
         dhlc_pkg::ST_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {rd_data.time_ps, rd_data.pos[2], rd_data.pos[1],
                            rd_data.pos[0], rd_data.energy, rd_data.volume};
            rsp_user_in  = {ovf_ff, 1'b0};
            rsp_last_in  = (idx_nx == cnt_ff);
            single_in    = 1'b0;
            state_in     = dhlc_pkg::ST_OUT_WAIT;
         end
         dhlc_pkg::ST_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (single_ff || rsp_last_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = dhlc_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_nx;
                  addr_in  = idx_nx[AW-1:0];
                  state_in = dhlc_pkg::ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = dhlc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhlc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dist_ff      <= '0;
         cmask_ff     <= '0;
         rmask_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               dhlc_pkg::CSR_KIND0_DIST:   dist_ff[0] <= csr_wdata;
               dhlc_pkg::CSR_KIND1_DIST:   dist_ff[1] <= csr_wdata;
               dhlc_pkg::CSR_KIND2_DIST:   dist_ff[2] <= csr_wdata;
               dhlc_pkg::CSR_KIND3_DIST:   dist_ff[3] <= csr_wdata;
               dhlc_pkg::CSR_CLUSTER_MASK: cmask_ff   <= csr_wdata[3:0];
               dhlc_pkg::CSR_REJECT_MASK:  rmask_ff   <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      jdx_ff      <= jdx_in;
      addr_ff     <= addr_in;
      acc_ff      <= acc_in;
      best_d_ff   <= best_d_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      axis_ff     <= axis_in;
      pc_ff       <= pc_in;
      ph_ff       <= ph_in;
      neg_ff      <= neg_in;
      newpos_ff   <= newpos_in;
      voli_ff     <= voli_in;
      rej_ff      <= rej_in;
      single_ff   <= single_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The fill count never passes the buffer depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond buffer depth");

   // Entries are dropped only once the buffer is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> cnt_ff == CW'(MAX_ENTRIES))
      else $error("overflow flagged with room left");

   // No new hit is taken while a result still waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("hit accepted while a result is pending");

   // A quotient arrives only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == dhlc_pkg::ST_MRG_DIV)
      else $error("divider finished outside a merge");

endmodule

>>> tb/dhlc_cluster_checker.sv
// Checker for the detector hit clustering block: predicts the result items and compares them.
module dhlc_cluster_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [159:0]                  req_tdata,
   input  logic [1:0]                    req_tuser,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [159:0]                  rsp_tdata,
   input  logic [1:0]                    rsp_tuser,
   input  logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [dhlc_pkg::CsrAW-1:0]    csr_addr,
   input  logic [dhlc_pkg::CsrW-1:0]     csr_wdata,
   output int                            err_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 64;

   typedef struct packed {
      logic [15:0] vol;
      logic [23:0] energy;
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
      logic [47:0] time_ps;
      logic        rejected;
      logic        overflow;
      logic        last;
   } cluster_result_type;

   // Mirror of the configuration registers.
   logic [23:0] merge_dist_sq [4];
   logic [3:0]  clus_mask;
   logic [3:0]  rej_mask;

   // Mirror of the entry buffer.
   logic [15:0] buf_vol [Depth];
   logic [1:0]  buf_kind [Depth];
   logic        buf_clus [Depth];
   logic [23:0] buf_energy [Depth];
   int          buf_pos [Depth][3];
   logic [47:0] buf_time [Depth];
   int          buf_count;
   logic        buf_overflow;

   cluster_result_type expected_results [$];

   assign pending = expected_results.size();

   // Energy-weighted coordinate, rounded to nearest with halves away from zero.
   function automatic int centroid_coord(int c, longint ec, int h, longint eh);
      longint num;
      longint den;
      num = longint'(c) * ec + longint'(h) * eh;
      den = ec + eh;
      if (den == 0) return c;
      if (num >= 0) return int'((num + den / 2) / den);
      return int'(-((-num + den / 2) / den));
   endfunction

   function automatic bit rejecting_entry(int i);
      return buf_clus[i] && rej_mask[buf_kind[i]];
   endfunction

   // Buffer one new entry, or flag the overflow when the buffer is full.
   task automatic append_entry(logic [15:0] vol, logic [1:0] kind, bit clus,
                               logic [23:0] en, int p [3], logic [47:0] t);
      if (buf_count >= Depth) begin
         buf_overflow = 1'b1;
         return;
      end
      buf_vol[buf_count] = vol;
      buf_kind[buf_count] = kind;
      buf_clus[buf_count] = clus;
      buf_energy[buf_count] = en;
      for (int a = 0; a < 3; a++) buf_pos[buf_count][a] = p[a];
      buf_time[buf_count] = t;
      buf_count++;
   endtask

   // Apply one accepted hit and queue the results it causes.
   task automatic predict_hit(logic [159:0] d, logic [1:0] kind, bit last);
      logic [15:0] vol;
      logic [23:0] en;
      logic [47:0] t;
      int p [3];
      bit found;
      int best;
      longint best_d;
      longint sq_dist;
      longint df;
      int unsigned esum;
      bit rejected;
      cluster_result_type r;
      vol = d[15:0];
      en = d[39:16];
      p[0] = int'(signed'(d[63:40]));
      p[1] = int'(signed'(d[87:64]));
      p[2] = int'(signed'(d[111:88]));
      t = d[159:112];
      found = 0;
      best = 0;
      best_d = 0;
      rejected = 0;

      if (clus_mask[kind]) begin
         // Nearest cluster of the same volume; the earliest wins a tie.
         for (int i = 0; i < buf_count; i++) begin
            if (!buf_clus[i] || buf_vol[i] != vol) continue;
            sq_dist = 0;
            for (int a = 0; a < 3; a++) begin
               df = longint'(p[a]) - longint'(buf_pos[i][a]);
               sq_dist += df * df;
            end
            if (!found || sq_dist < best_d) begin
               found = 1;
               best = i;
               best_d = sq_dist;
            end
         end
         if (found && best_d < longint'(merge_dist_sq[kind])) begin
            for (int a = 0; a < 3; a++)
               buf_pos[best][a] = centroid_coord(buf_pos[best][a], longint'(buf_energy[best]),
                                                 p[a], longint'(en));
            esum = buf_energy[best] + en;
            buf_energy[best] = (esum > 32'hFFFFFF) ? dhlc_pkg::EnMax : esum[23:0];
            if (t < buf_time[best]) buf_time[best] = t;
         end else begin
            append_entry(vol, kind, 1'b1, en, p, t);
         end
      end else begin
         append_entry(vol, kind, 1'b0, en, p, t);
      end

      if (!last) return;

      // Two rejecting clusters in one volume reject the whole event.
      for (int i = 0; i < buf_count && !rejected; i++) begin
         if (!rejecting_entry(i)) continue;
         for (int j = i + 1; j < buf_count; j++)
            if (rejecting_entry(j) && buf_vol[j] == buf_vol[i]) rejected = 1;
      end

      if (rejected || buf_count == 0) begin
         r = '0;
         r.rejected = rejected;
         r.overflow = buf_overflow;
         r.last = 1'b1;
         expected_results = {expected_results, r};
      end else begin
         for (int i = 0; i < buf_count; i++) begin
            r.vol = buf_vol[i];
            r.energy = buf_energy[i];
            r.x = buf_pos[i][0][23:0];
            r.y = buf_pos[i][1][23:0];
            r.z = buf_pos[i][2][23:0];
            r.time_ps = buf_time[i];
            r.rejected = 1'b0;
            r.overflow = buf_overflow;
            r.last = (i + 1 == buf_count);
            expected_results = {expected_results, r};
         end
      end
      buf_count = 0;
      buf_overflow = 1'b0;
   endtask

   // Compare one result item with the oldest expectation.
   task automatic compare_result();
      cluster_result_type e;
      if (expected_results.size() == 0) begin
         $error("result item arrived with no expectation waiting");
         err_count++;
         return;
      end
      e = expected_results.pop_front();
      if (rsp_tdata[15:0] !== e.vol) begin
         $error("out_volume_id: expected %0d, got %0d", e.vol, rsp_tdata[15:0]);
         err_count++;
      end
      if (rsp_tdata[39:16] !== e.energy) begin
         $error("out_energy: expected %0d, got %0d", e.energy, rsp_tdata[39:16]);
         err_count++;
      end
      if (rsp_tdata[63:40] !== e.x) begin
         $error("out_x: expected %0d, got %0d", signed'(e.x), signed'(rsp_tdata[63:40]));
         err_count++;
      end
      if (rsp_tdata[87:64] !== e.y) begin
         $error("out_y: expected %0d, got %0d", signed'(e.y), signed'(rsp_tdata[87:64]));
         err_count++;
      end
      if (rsp_tdata[111:88] !== e.z) begin
         $error("out_z: expected %0d, got %0d", signed'(e.z), signed'(rsp_tdata[111:88]));
         err_count++;
      end
      if (rsp_tdata[159:112] !== e.time_ps) begin
         $error("out_time: expected %0d, got %0d", e.time_ps, rsp_tdata[159:112]);
         err_count++;
      end
      if (rsp_tuser[0] !== e.rejected) begin
         $error("event_rejected: expected %0d, got %0d", e.rejected, rsp_tuser[0]);
         err_count++;
      end
      if (rsp_tuser[1] !== e.overflow) begin
         $error("buffer_overflow: expected %0d, got %0d", e.overflow, rsp_tuser[1]);
         err_count++;
      end
      if (rsp_tlast !== e.last) begin
         $error("last_result: expected %0d, got %0d", e.last, rsp_tlast);
         err_count++;
      end
   endtask

   initial err_count = 0;

   // Watch the configuration port and both channels at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) merge_dist_sq[k] <= '0;
         clus_mask <= '0;
         rej_mask <= '0;
         buf_count = 0;
         buf_overflow = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) compare_result();
         if (req_tvalid && req_tready) predict_hit(req_tdata, req_tuser, req_tlast);
         if (csr_we) begin
            case (csr_addr)
               dhlc_pkg::CSR_KIND0_DIST: merge_dist_sq[0] <= csr_wdata;
               dhlc_pkg::CSR_KIND1_DIST: merge_dist_sq[1] <= csr_wdata;
               dhlc_pkg::CSR_KIND2_DIST: merge_dist_sq[2] <= csr_wdata;
               dhlc_pkg::CSR_KIND3_DIST: merge_dist_sq[3] <= csr_wdata;
               dhlc_pkg::CSR_CLUSTER_MASK: clus_mask <= csr_wdata[3:0];
               dhlc_pkg::CSR_REJECT_MASK: rej_mask <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

endmodule

>>> tb/detector_hit_local_clustering_tb.sv
// Testbench top of the detector hit clustering block: clock, reset, stimulus and verdict.
module detector_hit_local_clustering_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 2000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [dhlc_pkg::CsrAW-1:0] csr_addr = '0;
   logic [dhlc_pkg::CsrW-1:0]  csr_wdata = '0;

   int  err_count;
   int  pending;
   int  hit_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  cycle_count = 0;
   int  hits_sent;
   bit  hold_go = 0;
   logic hold_on = 1'b0;

   detector_hit_local_clustering dut (.*);

   dhlc_cluster_checker checker_i (.*);

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result receiver: random stalls, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_on && ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (600) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Offer one hit and wait until it is accepted.
   task automatic send_hit(logic [15:0] vol, logic [1:0] kind, logic [23:0] en,
                           logic [23:0] x, logic [23:0] y, logic [23:0] z,
                           logic [47:0] t, bit last);
      while ($urandom_range(99) < hit_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {t, z, y, x, en, vol};
      req_tuser <= kind;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hits_sent++;
   endtask

   task automatic write_config(logic [23:0] d0, logic [23:0] d1, logic [23:0] d2,
                               logic [23:0] d3, logic [3:0] cmask, logic [3:0] rmask);
      logic [dhlc_pkg::CsrAW-1:0] idx [6];
      logic [dhlc_pkg::CsrW-1:0]  val [6];
      idx = '{dhlc_pkg::CSR_KIND0_DIST, dhlc_pkg::CSR_KIND1_DIST, dhlc_pkg::CSR_KIND2_DIST,
              dhlc_pkg::CSR_KIND3_DIST, dhlc_pkg::CSR_CLUSTER_MASK,
              dhlc_pkg::CSR_REJECT_MASK};
      val = '{d0, d1, d2, d3, {20'd0, cmask}, {20'd0, rmask}};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Wait until every expected result has come, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [23:0] near_coord(int center, int spread);
      return 24'(center + int'($urandom_range(2 * spread)) - spread);
   endfunction

   function automatic logic [23:0] random_energy();
      case ($urandom_range(7))
         0: return '0;
         1: return dhlc_pkg::EnMax;
         2: return 24'($urandom_range(255));
         default: return 24'($urandom);
      endcase
   endfunction

   // One event of random hits, most around a common point in three neighbouring volumes.
   task automatic random_event(int nhits);
      int cx;
      int cy;
      int cz;
      int spread;
      logic [15:0] vbase;
      cx = int'($urandom_range(8000000)) - 4000000;
      cy = int'($urandom_range(8000000)) - 4000000;
      cz = int'($urandom_range(8000000)) - 4000000;
      spread = ($urandom_range(1)) ? 40 : 3000;
      vbase = 16'($urandom);
      for (int h = 0; h < nhits; h++) begin
         if ($urandom_range(9) == 0)
            send_hit(16'($urandom), 2'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), {16'($urandom), 32'($urandom)},
                     h == nhits - 1);
         else
            send_hit(vbase + 16'($urandom_range(2)), 2'($urandom), random_energy(),
                     near_coord(cx, spread), near_coord(cy, spread),
                     near_coord(cz, spread), {16'($urandom), 32'($urandom)},
                     h == nhits - 1);
      end
   endtask

   task automatic random_phase(int items);
      int start;
      start = hits_sent;
      while (hits_sent - start < items) random_event($urandom_range(1, 7));
   endtask

   function automatic logic [23:0] random_dist();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return 24'($urandom_range(20000));
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      hits_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: kinds 0, 1 and 3 clustered, kind 2 passed through.
      write_config(24'hFFFFFF, 24'd100, 24'd0, 24'd5000, 4'b1011, 4'b0000);
      // A single hit at the field extremes.
      send_hit(16'hFFFF, 2'd0, dhlc_pkg::EnMax, 24'h7FFFFF, 24'h800000, 24'd0, '1, 1);
      // Saturating merge with half-way centroids, a zero-energy merge and plain hits.
      send_hit(16'd5, 2'd0, dhlc_pkg::EnMax, 24'd100, -24'sd100, 24'd7, 48'd50, 0);
      send_hit(16'd5, 2'd0, dhlc_pkg::EnMax, 24'd103, -24'sd90, 24'd8, 48'd20, 0);
      send_hit(16'd6, 2'd1, 24'd0, 24'd10, 24'd10, 24'd10, 48'd5, 0);
      send_hit(16'd6, 2'd1, 24'd0, 24'd12, 24'd10, 24'd10, 48'd9, 0);
      send_hit(16'd6, 2'd1, 24'd7, -24'sd30, 24'd10, 24'd10, 48'd1, 0);
      send_hit(16'd6, 2'd2, 24'd1, 24'd0, 24'd0, 24'd0, 48'd0, 0);
      send_hit(16'd6, 2'd2, 24'd1, 24'd0, 24'd0, 24'd0, 48'd0, 1);
      // Equal distance to two clusters: the earlier one takes the hit.
      send_hit(16'd9, 2'd3, 24'd3, -24'sd1, -24'sd1, -24'sd1, 48'd40, 0);
      send_hit(16'd9, 2'd3, 24'd2, 24'd99, -24'sd1, -24'sd1, 48'd30, 0);
      send_hit(16'd9, 2'd3, 24'd2, 24'd49, -24'sd1, -24'sd1, 48'd60, 0);
      send_hit(16'd9, 2'd1, 24'd5, -24'sd3, -24'sd4, -24'sd5, 48'd2, 0);
      send_hit(16'd9, 2'd1, 24'd6, -24'sd4, -24'sd4, -24'sd5, 48'd3, 1);
      drain();
      // Two clusters of a rejecting kind in one volume, and a clean event.
      write_config(24'hFFFFFF, 24'd100, 24'd0, 24'd5000, 4'b1011, 4'b1000);
      send_hit(16'd12, 2'd3, 24'd10, 24'd0, 24'd0, 24'd0, 48'd1, 0);
      send_hit(16'd12, 2'd2, 24'd10, 24'd0, 24'd0, 24'd0, 48'd1, 0);
      send_hit(16'd12, 2'd3, 24'd10, 24'd1000, 24'd0, 24'd0, 48'd1, 1);
      send_hit(16'd12, 2'd3, 24'd10, 24'd0, 24'd0, 24'd0, 48'd1, 0);
      send_hit(16'd13, 2'd3, 24'd10, 24'd1000, 24'd0, 24'd0, 48'd1, 1);
      drain();

      // Random phase with no idling and random settings.
      write_config(random_dist(), random_dist(), random_dist(), random_dist(),
                   4'($urandom), 4'($urandom));
      random_phase(20);
      drain();

      // Sender idles; nothing ever merges and every kind rejects.
      hit_idle_pct = 47;
      write_config('0, '0, '0, '0, 4'hF, 4'hF);
      random_phase(20);
      drain();

      // Receiver stalls, with one long hold-off; everything near merges.
      hit_idle_pct = 0;
      rsp_stall_pct = 47;
      write_config('1, '1, '1, '1, 4'hF, 4'($urandom));
      hold_go = 1;
      random_phase(20);
      drain();

      // Both idle; one event overflows the buffer.
      hit_idle_pct = 25;
      rsp_stall_pct = 25;
      write_config(random_dist(), random_dist(), random_dist(), random_dist(),
                   4'($urandom), 4'b0000);
      for (int h = 0; h < 67; h++)
         send_hit(16'(h % 66), 2'd0, 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), {16'($urandom), 32'($urandom)}, h == 66);
      random_phase(10);
      drain();

      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
